// File: hdl/npc_pkg.sv
package npc_pkg;

  // Fixed field widths
  localparam int PIDX_W     = 9;
  localparam int COUNT_W    = 10;
  localparam int DIST_W     = 22;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_THRESHOLD = 2'd1;

  // Item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // 9999 cm^2 in units of 1/256 cm^2, and the threshold after reset (5.5 cm^2)
  localparam logic [DIST_W-1:0] SENTINEL_SQ  = 22'd2559744;
  localparam logic [DIST_W-1:0] THRESH_RESET = 22'd1408;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMPTY,
    ST_WAIT
  } npc_state_e;

  // Travels alongside each stored point through the distance pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } scan_tag_t;

endpackage

// File: hdl/npc_store.sv
module npc_store #(
  parameter int DEPTH  = 512,
  parameter int DATA_W = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/npc_dist.sv
module npc_dist
  import npc_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int AW         = 9,
  parameter int SW         = 2 * COORD_BITS + 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [COORD_BITS-1:0] qx_i,
  input  logic signed [COORD_BITS-1:0] qy_i,
  input  logic [2*COORD_BITS-1:0]     rd_data_i,
  input  scan_tag_t                   tag_i,
  input  logic [AW-1:0]               idx_i,
  output scan_tag_t                   tag_o,
  output logic [AW-1:0]               idx_o,
  output logic [SW-1:0]               dist_o
);

  localparam int CB  = COORD_BITS;
  localparam int SQW = 2 * CB + 2;

  // Stage 0 aligns the tag with the memory read data
  scan_tag_t tag0_q, tag1_q, tag2_q, tag3_q;
  logic [AW-1:0] idx0_q, idx1_q, idx2_q, idx3_q;

  logic [CB:0]    dx_u, dy_u;
  logic [CB:0]    mx_d, my_d, mx_q, my_q;
  logic [SQW-1:0] sqx_d, sqy_d, sqx_q, sqy_q;
  logic [SW-1:0]  sum_d, sum_q;

  always_comb begin
    dx_u = {qx_i[CB-1], qx_i} - {rd_data_i[CB-1], rd_data_i[CB-1:0]};
    dy_u = {qy_i[CB-1], qy_i} - {rd_data_i[2*CB-1], rd_data_i[2*CB-1:CB]};
    mx_d = dx_u[CB] ? (~dx_u + 1'b1) : dx_u;
    my_d = dy_u[CB] ? (~dy_u + 1'b1) : dy_u;
    sqx_d = SQW'(mx_q) * SQW'(mx_q);
    sqy_d = SQW'(my_q) * SQW'(my_q);
    sum_d = SW'(sqx_q) + SW'(sqy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag0_q <= tag_i;
      tag1_q <= tag0_q;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx0_q <= idx_i;
    idx1_q <= idx0_q;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    mx_q   <= mx_d;
    my_q   <= my_d;
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
    sum_q  <= sum_d;
  end

  assign tag_o  = tag3_q;
  assign idx_o  = idx3_q;
  assign dist_o = sum_q;

endmodule

// File: hdl/npc_best.sv
module npc_best
  import npc_pkg::*;
#(
  parameter int AW = 9,
  parameter int SW = 35
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              init_i,
  input  logic              empty_i,
  input  scan_tag_t         tag_i,
  input  logic [AW-1:0]     idx_i,
  input  logic [SW-1:0]     dist_i,
  input  logic [DIST_W-1:0] thr_i,
  input  logic [PIDX_W-1:0] src_i,
  output logic              done_o,
  output logic [PIDX_W-1:0] source_index_o,
  output logic              matched_o,
  output logic [PIDX_W-1:0] target_index_o,
  output logic [DIST_W-1:0] min_sq_distance_o
);

  localparam int CMPW = (SW > DIST_W) ? SW : DIST_W;
  localparam int IW   = (AW > PIDX_W) ? AW : PIDX_W;

  logic [DIST_W-1:0] best_q, best_d;
  logic [AW-1:0]     best_idx_q, best_idx_d;
  logic              found_q, found_d;
  logic              fin_q, fin_d;
  logic              done_q;
  logic              closer;
  logic              ok;
  logic [IW-1:0]     best_idx_wide;

  logic [PIDX_W-1:0] src_out_q, tgt_out_q;
  logic              matched_q;
  logic [DIST_W-1:0] dist_out_q;

  always_comb begin
    closer     = tag_i.valid && (CMPW'(dist_i) < CMPW'(best_q));
    best_d     = best_q;
    best_idx_d = best_idx_q;
    found_d    = found_q;
    if (init_i) begin
      best_d     = SENTINEL_SQ;
      best_idx_d = '0;
      found_d    = 1'b0;
    end else if (closer) begin
      best_d     = DIST_W'(dist_i);
      best_idx_d = idx_i;
      found_d    = 1'b1;
    end
    fin_d         = (tag_i.valid && tag_i.last) || empty_i;
    ok            = found_q && (best_q < thr_i);
    best_idx_wide = IW'(best_idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q   <= 1'b0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      fin_q   <= fin_d;
      done_q  <= fin_q;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    if (fin_q) begin
      src_out_q  <= src_i;
      matched_q  <= ok;
      tgt_out_q  <= ok ? best_idx_wide[PIDX_W-1:0] : '0;
      dist_out_q <= best_q;
    end
  end

  assign done_o            = done_q;
  assign source_index_o    = src_out_q;
  assign matched_o         = matched_q;
  assign target_index_o    = tgt_out_q;
  assign min_sq_distance_o = dist_out_q;

endmodule

// File: hdl/nearest_point_correspondence_unit.sv
// Brute-force nearest point search. A load (mode 0) writes one target point
// into the point store and keeps busy_o low. A query (mode 1) scans stored
// slots 0 to target_count-1 (capped at MAX_POINTS), one slot per cycle from
// the single read port of the point store, with busy_o high throughout.
// Exactly one result per query appears for one cycle with done_o high, in the
// last busy cycle; the receiver cannot stall it, so it must take the beat in
// that cycle. The user must write registers through cfg_we_i only while
// busy_o is low; the block itself does not enforce this. Slots must be
// loaded before a query scans them.
module nearest_point_correspondence_unit
  import npc_pkg::*;
#(
  parameter int MAX_POINTS = 512,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         mode_i,
  input  logic [PIDX_W-1:0]            point_index_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata_i,
  output logic                         done_o,
  output logic [PIDX_W-1:0]            source_index_o,
  output logic                         matched_o,
  output logic [PIDX_W-1:0]            target_index_o,
  output logic [DIST_W-1:0]            min_sq_distance_o
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int IW = (AW > PIDX_W) ? AW : PIDX_W;
  localparam int NW = (COUNT_W > $clog2(MAX_POINTS + 1)) ? COUNT_W : $clog2(MAX_POINTS + 1);
  localparam int SW = 2 * COORD_BITS + 3;

  npc_state_e state_q, state_d;

  logic [COUNT_W-1:0] count_q;
  logic [DIST_W-1:0]  thr_q;

  logic [AW-1:0]     j_q, j_d;
  logic [AW-1:0]     last_q, last_d;
  logic signed [COORD_BITS-1:0] qx_q, qy_q;
  logic [PIDX_W-1:0] src_q;

  logic          accept;
  logic          query_go;
  logic          load_go;
  logic [IW-1:0] pidx_wide;
  logic [NW-1:0] n_sat;
  logic          rd_en;
  logic          empty_pulse;
  scan_tag_t     scan_tag;

  scan_tag_t         dist_tag;
  logic [AW-1:0]     dist_idx;
  logic [SW-1:0]     dist_sum;
  logic [2*COORD_BITS-1:0] rd_data;

  assign accept    = start_i && !busy_o;
  assign query_go  = accept && (mode_i == MODE_QUERY);
  assign pidx_wide = IW'(point_index_i);
  // Drop loads aimed beyond the store
  assign load_go   = accept && (mode_i == MODE_LOAD) &&
                     (32'(point_index_i) < 32'(MAX_POINTS));

  always_comb begin
    n_sat = (NW'(count_q) > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(count_q);
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      thr_q   <= THRESH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TARGET_COUNT:     count_q <= cfg_wdata_i[COUNT_W-1:0];
        REG_ACCEPT_THRESHOLD: thr_q   <= cfg_wdata_i[DIST_W-1:0];
        default:              ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    last_q <= last_d;
    if (query_go) begin
      qx_q  <= coord_x_i;
      qy_q  <= coord_y_i;
      src_q <= point_index_i;
    end
  end

  always_comb begin
    state_d        = state_q;
    j_d            = j_q;
    last_d         = last_q;
    rd_en          = 1'b0;
    empty_pulse    = 1'b0;
    scan_tag.valid = 1'b0;
    scan_tag.last  = 1'b0;
    busy_o         = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (query_go) begin
          j_d    = '0;
          last_d = AW'(n_sat - 1'b1);
          state_d = (n_sat == '0) ? ST_EMPTY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en          = 1'b1;
        scan_tag.valid = 1'b1;
        scan_tag.last  = (j_q == last_q);
        j_d            = j_q + 1'b1;
        if (j_q == last_q) begin
          state_d = ST_WAIT;
        end
      end
      ST_EMPTY: begin
        empty_pulse = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        if (done_o) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  npc_store #(
    .DEPTH  (MAX_POINTS),
    .DATA_W (2 * COORD_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (load_go),
    .wr_addr_i (pidx_wide[AW-1:0]),
    .wr_data_i ({coord_y_i, coord_x_i}),
    .rd_en_i   (rd_en),
    .rd_addr_i (j_q),
    .rd_data_o (rd_data)
  );

  npc_dist #(
    .COORD_BITS (COORD_BITS),
    .AW         (AW),
    .SW         (SW)
  ) u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .qx_i      (qx_q),
    .qy_i      (qy_q),
    .rd_data_i (rd_data),
    .tag_i     (scan_tag),
    .idx_i     (j_q),
    .tag_o     (dist_tag),
    .idx_o     (dist_idx),
    .dist_o    (dist_sum)
  );

  npc_best #(
    .AW (AW),
    .SW (SW)
  ) u_best (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .init_i            (query_go),
    .empty_i           (empty_pulse),
    .tag_i             (dist_tag),
    .idx_i             (dist_idx),
    .dist_i            (dist_sum),
    .thr_i             (thr_q),
    .src_i             (src_q),
    .done_o            (done_o),
    .source_index_o    (source_index_o),
    .matched_o         (matched_o),
    .target_index_o    (target_index_o),
    .min_sq_distance_o (min_sq_distance_o)
  );

`ifndef SYNTHESIS
  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result beat outside a query");

  a_query_holds_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == MODE_QUERY) |=> busy_o)
    else $error("query accepted without going busy");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy_o))
    else $error("more than one result beat per query");

  a_match_below_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && matched_o) |-> (min_sq_distance_o < thr_q))
    else $error("match reported at or above threshold");

  a_nomatch_zero_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !matched_o) |-> (target_index_o == '0))
    else $error("target index set without a match");
`endif

endmodule
